// ----- rtl/dtmp_pkg.sv -----
// Shared constants, types and the tangent table for the depth to top-down map projection.
package dtmp_pkg;

   // Map, table and frame limits
   localparam int MAP_WIDTH        = 640;
   localparam int MAP_HEIGHT       = 480;
   localparam int TAN_TABLE_DEPTH  = 1024;  // power of two
   localparam int MAX_FRAME_HEIGHT = 4096;

   // Port field widths
   localparam int RAW_W      = 16;
   localparam int COL_W      = 12;
   localparam int ROW_W      = 12;
   localparam int SCALE_W    = 24;
   localparam int FW_W       = 13;
   localparam int RECIP_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int MAP_COL_W  = 10;
   localparam int MAP_ROW_W  = 9;
   localparam int BLUE_W     = 7;
   localparam int RED_W      = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_RECIP = 2'd2;

   // Register reset values
   localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST = 24'd65536;
   localparam logic [FW_W-1:0]    FRAME_WIDTH_RST = 13'd640;
   localparam logic [RECIP_W-1:0] WIDTH_RECIP_RST = 24'd26214;

   localparam int ROW_CMP_W = 13;
   localparam logic [ROW_CMP_W-1:0] FRAME_ROW_LIMIT = ROW_CMP_W'(MAX_FRAME_HEIGHT);

   // Depth in mm, 8 fraction bits
   localparam int D8_FRAC   = 8;
   localparam int D8_FULL_W = RAW_W + SCALE_W - D8_FRAC;
   localparam int D8_W      = $clog2(4000 * 256 + 1);
   localparam logic [D8_FULL_W-1:0] MIN_D8   = D8_FULL_W'(200 * 256);
   localparam logic [D8_FULL_W-1:0] MAX_D8   = D8_FULL_W'(4000 * 256);
   localparam logic [D8_W-1:0]      MAX_D8_N = D8_W'(4000 * 256);

   // Map dimension multipliers
   localparam int MAP_DIM_W = 13;

   // Tangent, signed Q2.14
   localparam int TAN_FRAC  = 14;
   localparam int TAN_W     = 16;
   localparam int TMAG_W    = 15;
   localparam int TAN_IDX_W = $clog2(TAN_TABLE_DEPTH);

   // Angle ratio (2*column - width) * reciprocal, Q.24
   localparam int ANG_FRAC   = 24;
   localparam int ANG_W      = FW_W + 1;
   localparam int ANG_PROD_W = ANG_W + RECIP_W + 1;
   localparam int ANG_SUM_W  = ANG_PROD_W + 1;
   localparam int IDX_SHIFT  = ANG_FRAC + 1 - TAN_IDX_W;
   localparam logic signed [ANG_SUM_W-1:0] ANG_ONE = ANG_SUM_W'(longint'(1) <<< ANG_FRAC);
   localparam logic [ANG_SUM_W-1:0] TAN_IDX_LAST = ANG_SUM_W'(TAN_TABLE_DEPTH - 1);

   // Tangent table banking: each bank at most 256 entries
   localparam int TAN_BANK_DEPTH = (TAN_TABLE_DEPTH < 256) ? TAN_TABLE_DEPTH : 256;
   localparam int TAN_BANKS      = TAN_TABLE_DEPTH / TAN_BANK_DEPTH;
   localparam int TAN_BANK_W     = $clog2(TAN_BANK_DEPTH);
   localparam int TAN_SEL_W      = (TAN_BANKS > 1) ? $clog2(TAN_BANKS) : 1;

   // Horizontal offset: d8 * tan * MAP_WIDTH / (2^25 * 1000)
   localparam int OFF_SHIFT = D8_FRAC + TAN_FRAC + 3;
   localparam int OFF_DIV   = 1000;
   localparam int OFF_N_W   = D8_W + TMAG_W + MAP_DIM_W - OFF_SHIFT;
   localparam int OFF_S     = OFF_N_W + $clog2(OFF_DIV);
   localparam int OFF_R_W   = OFF_S - $clog2(OFF_DIV) + 2;
   localparam int OFF_Q_W   = OFF_N_W - $clog2(OFF_DIV) + 1;
   localparam logic [OFF_R_W-1:0] OFF_RECIP =
      OFF_R_W'(((longint'(1) <<< OFF_S) + OFF_DIV - 1) / OFF_DIV);

   // Map row: d8 * MAP_HEIGHT / (2^10 * 1000)
   localparam int MY_SHIFT = D8_FRAC + 2;
   localparam int MY_DIV   = 1000;
   localparam int MY_N_W   = D8_W + MAP_DIM_W - MY_SHIFT;
   localparam int MY_S     = MY_N_W + $clog2(MY_DIV);
   localparam int MY_R_W   = MY_S - $clog2(MY_DIV) + 2;
   localparam int MY_Q_W   = MY_N_W - $clog2(MY_DIV) + 1;
   localparam logic [MY_R_W-1:0] MY_RECIP =
      MY_R_W'(((longint'(1) <<< MY_S) + MY_DIV - 1) / MY_DIV);

   // Colour levels: whole mm / 40 and (4000 mm - d) / 20
   localparam int MM_W     = D8_W - D8_FRAC;
   localparam int BLUE_DIV = 40;
   localparam int BLUE_S   = MM_W + $clog2(BLUE_DIV);
   localparam int BLUE_R_W = BLUE_S - $clog2(BLUE_DIV) + 2;
   localparam logic [BLUE_R_W-1:0] BLUE_RECIP =
      BLUE_R_W'(((longint'(1) <<< BLUE_S) + BLUE_DIV - 1) / BLUE_DIV);
   localparam int RED_DIV  = 20;
   localparam int RED_S    = MM_W + $clog2(RED_DIV);
   localparam int RED_R_W  = RED_S - $clog2(RED_DIV) + 2;
   localparam logic [RED_R_W-1:0] RED_RECIP =
      RED_R_W'(((longint'(1) <<< RED_S) + RED_DIV - 1) / RED_DIV);

   // Table build, evaluated at elaboration only
   localparam longint PI_THIRD_Q30 = 64'sd1124419809;
   localparam longint ONE_Q30      = 64'sd1073741824;

   typedef logic signed [TAN_W-1:0] tan_table_type [TAN_TABLE_DEPTH];

   // Shift-subtract division of non-negative values
   function automatic longint udiv(longint num, longint den);
      longint quo;
      longint rem;
      quo = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'sd1 <<< b);
         end
      end
      return quo;
   endfunction

   // tan of entry i: angle (i - depth/2)/depth * pi/3, sin and cos by Taylor series in Q30
   function automatic logic signed [TAN_W-1:0] tan_entry(int i);
      longint m;
      longint mag;
      longint x;
      longint x2;
      longint s;
      longint c;
      longint ts;
      longint tc;
      longint t;
      logic   neg;
      m   = longint'(i) - longint'(TAN_TABLE_DEPTH / 2);
      neg = (m < 0);
      mag = neg ? -m : m;
      x   = (mag * PI_THIRD_Q30) / TAN_TABLE_DEPTH;
      x2  = (x * x) >>> 30;
      s   = x;
      c   = ONE_Q30;
      ts  = x;
      tc  = ONE_Q30;
      ts  = ((ts * x2) >>> 30) / 6;
      tc  = ((tc * x2) >>> 30) / 2;
      s   = s - ts;
      c   = c - tc;
      ts  = ((ts * x2) >>> 30) / 20;
      tc  = ((tc * x2) >>> 30) / 12;
      s   = s + ts;
      c   = c + tc;
      ts  = ((ts * x2) >>> 30) / 42;
      tc  = ((tc * x2) >>> 30) / 30;
      s   = s - ts;
      c   = c - tc;
      ts  = ((ts * x2) >>> 30) / 72;
      tc  = ((tc * x2) >>> 30) / 56;
      s   = s + ts;
      c   = c + tc;
      t   = udiv((s <<< TAN_FRAC) + (c >>> 1), c);
      return TAN_W'(neg ? -t : t);
   endfunction

   function automatic tan_table_type build_tan_table();
      tan_table_type tbl;
      for (int i = 0; i < TAN_TABLE_DEPTH; i++) begin
         tbl[i] = tan_entry(i);
      end
      return tbl;
   endfunction

   localparam tan_table_type TAN_TABLE = build_tan_table();

endpackage

// ----- rtl/dtmp_tan_rom.sv -----
// Banked tangent ROM with a registered bank read and a registered bank select.
module dtmp_tan_rom (
   input  logic                               clock,
   input  logic [dtmp_pkg::TAN_IDX_W-1:0]     idx,
   output logic signed [dtmp_pkg::TAN_W-1:0]  tan_q
);
   import dtmp_pkg::*;

   logic signed [TAN_W-1:0] bank_in [TAN_BANKS];
   logic signed [TAN_W-1:0] bank_ff [TAN_BANKS];
   logic [TAN_SEL_W-1:0]    sel_in;
   logic [TAN_SEL_W-1:0]    sel_ff;
   logic signed [TAN_W-1:0] tan_in;
   logic signed [TAN_W-1:0] tan_ff;
   logic [TAN_BANK_W-1:0]   lo;

   assign lo     = idx[TAN_BANK_W-1:0];
   assign sel_in = TAN_SEL_W'(idx >> TAN_BANK_W);

   // every bank looks up the low address bits
   for (genvar b = 0; b < TAN_BANKS; b++) begin : g_bank
      localparam logic [TAN_IDX_W-1:0] BASE = TAN_IDX_W'(b * TAN_BANK_DEPTH);
      assign bank_in[b] = TAN_TABLE[BASE | TAN_IDX_W'(lo)];
   end

   // the registered bank select picks among the registered bank reads
   assign tan_in = bank_ff[sel_ff];

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      sel_ff  <= sel_in;
      tan_ff  <= tan_in;
   end

   assign tan_q = tan_ff;

endmodule

// ----- rtl/depth_to_topdown_map_projection.sv -----
// Top level: depth pixel to top-down map point, nine-stage pipeline.
//
//   Channel  | Ports                                          | Transfer when
//   ---------+------------------------------------------------+---------------------------
//   request  | start, busy, req_depth_raw, req_column, req_row | start && !busy at clock edge
//   response | rsp_valid, rsp_map_col/row, rsp_blue/red_level  | rsp_valid, held one cycle
//   csr      | csr_wr_en, csr_index, csr_wdata                 | csr_wr_en at clock edge
//
// One pixel enters per cycle; busy stays low. A kept pixel's result passes through every
// stage, the multiplier stages and the registered banked tangent ROM among them.
// Skipped pixels leave a one-cycle gap in the response strobe and nothing else.
// Synchronous reset empties the pipeline and restores the register defaults.
// Responses cannot be held off; each one is on the ports for exactly one cycle.
module depth_to_topdown_map_projection (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [dtmp_pkg::RAW_W-1:0]         req_depth_raw,
   input  logic [dtmp_pkg::COL_W-1:0]         req_column,
   input  logic [dtmp_pkg::ROW_W-1:0]         req_row,
   output logic                               rsp_valid,
   output logic [dtmp_pkg::MAP_COL_W-1:0]     rsp_map_col,
   output logic [dtmp_pkg::MAP_ROW_W-1:0]     rsp_map_row,
   output logic [dtmp_pkg::BLUE_W-1:0]        rsp_blue_level,
   output logic [dtmp_pkg::RED_W-1:0]         rsp_red_level,
   input  logic                               csr_wr_en,
   input  logic [dtmp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dtmp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dtmp_pkg::*;

   typedef struct packed {
      logic [MY_Q_W-1:0] row;
      logic [BLUE_W-1:0] blue;
      logic [RED_W-1:0]  red;
   } dist_type;

   localparam int PIPE_LAT = 9;
   localparam logic [OFF_Q_W:0] HALF_W   = (OFF_Q_W + 1)'(MAP_WIDTH / 2);
   localparam logic [OFF_Q_W:0] RIGHT_W  = (OFF_Q_W + 1)'(MAP_WIDTH - 1 - MAP_WIDTH / 2);
   localparam logic [MY_Q_W-1:0] MAP_H_Q = MY_Q_W'(MAP_HEIGHT);

   // configuration registers
   logic [SCALE_W-1:0] depth_scale_ff;
   logic [FW_W-1:0]    frame_width_ff;
   logic [RECIP_W-1:0] width_recip_ff;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v2_in, v3_in, out_ok_in;

   // stage 1: captured request
   logic [RAW_W-1:0] raw1_ff;
   logic [COL_W-1:0] col1_ff;
   logic [ROW_W-1:0] row1_ff;

   // stage 2: depth product and angle product
   logic [RAW_W+SCALE_W-1:0]       dprod;
   logic [D8_FULL_W-1:0]           d8_2_in, d8_2_ff;
   logic signed [ANG_W-1:0]        ang_diff;
   logic signed [RECIP_W:0]        recip_s;
   logic signed [ANG_PROD_W-1:0]   ang2_in, ang2_ff;

   // stage 3: range check, table index, row and colour numerators
   logic signed [ANG_SUM_W-1:0]    ang_sum;
   logic [ANG_SUM_W-1:0]           idx_wide;
   logic [TAN_IDX_W-1:0]           idx3_in, idx3_ff;
   logic [D8_W-1:0]                d8_3_ff;
   logic [D8_W+MAP_DIM_W-1:0]      mprod;
   logic [MY_N_W-1:0]              my_n3_in, my_n3_ff;
   logic [D8_W-1:0]                red_d;
   logic [MM_W-1:0]                blue_n3_ff, red_n3_ff, red_n3_in;

   // stage 4 to 8: distance fields travel alongside
   logic [MY_N_W+MY_R_W-1:0]       my_prod;
   logic [MM_W+BLUE_R_W-1:0]       blue_prod;
   logic [MM_W+RED_R_W-1:0]        red_prod;
   dist_type                       dist4_in, dist4_ff, dist5_ff, dist6_ff, dist7_ff, dist8_ff;
   logic [D8_W-1:0]                d8_4_ff, d8_5_ff;

   // stage 5 to 8: horizontal offset
   logic signed [TAN_W-1:0]        tan5;
   logic [TMAG_W-1:0]              tmag;
   logic [D8_W+TMAG_W-1:0]         p6_in, p6_ff;
   logic                           neg6_ff, neg7_ff, neg8_ff;
   logic [D8_W+TMAG_W+MAP_DIM_W-1:0] nprod;
   logic [OFF_N_W-1:0]             noff7_in, noff7_ff;
   logic [OFF_N_W+OFF_R_W-1:0]     off_prod;
   logic [OFF_Q_W-1:0]             off8_in, off8_ff;

   // stage 9: output registers
   logic [OFF_Q_W:0]               mx;
   logic                           col_ok;
   logic                           rsp_valid_ff;
   logic [MAP_COL_W-1:0]           map_col_ff;
   logic [MAP_ROW_W-1:0]           map_row_ff;
   logic [BLUE_W-1:0]              blue_ff;
   logic [RED_W-1:0]               red_ff;

   assign busy = 1'b0;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= DEPTH_SCALE_RST;
         frame_width_ff <= FRAME_WIDTH_RST;
         width_recip_ff <= WIDTH_RECIP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata[FW_W-1:0];
            CSR_WIDTH_RECIP: width_recip_ff <= csr_wdata[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 2: pixel selection, depth scaling, angle ratio
   always_comb begin
      v2_in = v1_ff && (col1_ff[1:0] == 2'b00) && (row1_ff[1:0] == 2'b00)
              && ({1'b0, col1_ff} < frame_width_ff)
              && ({1'b0, row1_ff} < FRAME_ROW_LIMIT)
              && (raw1_ff != '0);
      dprod    = raw1_ff * depth_scale_ff;
      d8_2_in  = dprod[RAW_W+SCALE_W-1:D8_FRAC];
      ang_diff = $signed({1'b0, col1_ff, 1'b0}) - $signed({1'b0, frame_width_ff});
      recip_s  = $signed({1'b0, width_recip_ff});
      ang2_in  = ang_diff * recip_s;
   end

   // stage 3: distance window, clamped table index, numerators
   always_comb begin
      v3_in    = v2_ff && (d8_2_ff >= MIN_D8) && (d8_2_ff <= MAX_D8);
      ang_sum  = ANG_SUM_W'(ang2_ff) + ANG_ONE;
      idx_wide = unsigned'(ang_sum) >> IDX_SHIFT;
      if (ang_sum[ANG_SUM_W-1]) begin
         idx3_in = '0;
      end else if (idx_wide > TAN_IDX_LAST) begin
         idx3_in = TAN_IDX_W'(TAN_TABLE_DEPTH - 1);
      end else begin
         idx3_in = idx_wide[TAN_IDX_W-1:0];
      end
      mprod     = d8_2_ff[D8_W-1:0] * MAP_DIM_W'(MAP_HEIGHT);
      my_n3_in  = mprod[MY_SHIFT +: MY_N_W];
      red_d     = MAX_D8_N - d8_2_ff[D8_W-1:0];
      red_n3_in = red_d[D8_W-1:D8_FRAC];
   end

   // stage 4: divisions by constants through reciprocals
   always_comb begin
      my_prod       = my_n3_ff * MY_RECIP;
      blue_prod     = blue_n3_ff * BLUE_RECIP;
      red_prod      = red_n3_ff * RED_RECIP;
      dist4_in.row  = my_prod[MY_S +: MY_Q_W];
      dist4_in.blue = blue_prod[BLUE_S +: BLUE_W];
      dist4_in.red  = red_prod[RED_S +: RED_W];
   end

   // tangent lookup: registered bank read and select, then registered output
   dtmp_tan_rom u_tan_rom (
      .clock (clock),
      .idx   (idx3_ff),
      .tan_q (tan5)
   );

   // stages 6 to 8: offset magnitude, scale to map, divide by 1000
   always_comb begin
      tmag     = tan5[TAN_W-1] ? TMAG_W'(-tan5) : TMAG_W'(tan5);
      p6_in    = d8_5_ff * tmag;
      nprod    = p6_ff * MAP_DIM_W'(MAP_WIDTH);
      noff7_in = nprod[OFF_SHIFT +: OFF_N_W];
      off_prod = noff7_ff * OFF_RECIP;
      off8_in  = off_prod[OFF_S +: OFF_Q_W];
   end

   // stage 9: centre the offset and check the map bounds
   always_comb begin
      if (neg8_ff) begin
         col_ok = ({1'b0, off8_ff} <= HALF_W);
         mx     = HALF_W - {1'b0, off8_ff};
      end else begin
         col_ok = ({1'b0, off8_ff} <= RIGHT_W);
         mx     = HALF_W + {1'b0, off8_ff};
      end
      out_ok_in = v8_ff && col_ok && (dist8_ff.row < MAP_H_Q);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= start && !busy;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         rsp_valid_ff <= out_ok_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      raw1_ff    <= req_depth_raw;
      col1_ff    <= req_column;
      row1_ff    <= req_row;
      d8_2_ff    <= d8_2_in;
      ang2_ff    <= ang2_in;
      idx3_ff    <= idx3_in;
      d8_3_ff    <= d8_2_ff[D8_W-1:0];
      my_n3_ff   <= my_n3_in;
      blue_n3_ff <= d8_2_ff[D8_W-1:D8_FRAC];
      red_n3_ff  <= red_n3_in;
      dist4_ff   <= dist4_in;
      d8_4_ff    <= d8_3_ff;
      dist5_ff   <= dist4_ff;
      d8_5_ff    <= d8_4_ff;
      dist6_ff   <= dist5_ff;
      p6_ff      <= p6_in;
      neg6_ff    <= tan5[TAN_W-1];
      dist7_ff   <= dist6_ff;
      noff7_ff   <= noff7_in;
      neg7_ff    <= neg6_ff;
      dist8_ff   <= dist7_ff;
      off8_ff    <= off8_in;
      neg8_ff    <= neg7_ff;
      map_col_ff <= mx[MAP_COL_W-1:0];
      map_row_ff <= dist8_ff.row[MAP_ROW_W-1:0];
      blue_ff    <= dist8_ff.blue;
      red_ff     <= dist8_ff.red;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_map_col    = map_col_ff;
   assign rsp_map_row    = map_row_ff;
   assign rsp_blue_level = blue_ff;
   assign rsp_red_level  = red_ff;

   // every response traces back to an earlier request transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("response without a request transfer at pipeline latency");

   // blue and red come from the same distance: 2*blue + red stays within 198..200
   a_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((9'({rsp_blue_level, 1'b0}) + 9'(rsp_red_level)) >= 9'd198) &&
                    ((9'({rsp_blue_level, 1'b0}) + 9'(rsp_red_level)) <= 9'd200))
      else $error("blue and red levels disagree on distance");

   // bounds check in the last stage keeps points on the map
   a_on_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_map_col < MAP_COL_W'(MAP_WIDTH)) &&
                    (rsp_map_row < MAP_ROW_W'(MAP_HEIGHT)))
      else $error("map point outside the map");

endmodule

// ----- tb/depth_to_topdown_map_projection_test.sv -----
// Self-checking testbench for the depth pixel to top-down map projection block.
`timescale 1ns / 100ps

module depth_to_topdown_map_projection_test;
   import dtmp_pkg::*;

   // Pipeline depth of a kept pixel; the drain wait covers skipped pixels still in flight
   localparam int PIPE_DEPTH   = 9;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int SHAPED_GOAL  = 270;
   localparam int NUM_PROBES   = 19;

   // Fixed-point constants of the projection
   localparam longint ANGLE_SPAN_Q30 = 64'sd1124419809;  // pi/3 in Q30
   localparam longint UNIT_Q30       = 64'sd1073741824;
   localparam longint NEAR_MM_Q8     = 64'sd51200;       // 200 mm
   localparam longint FAR_MM_Q8      = 64'sd1024000;     // 4000 mm
   localparam longint OFFSET_DIV     = 64'sd33554432000; // 256 * 1000 * 16384 * 8
   localparam longint ROW_DIV        = 64'sd1024000;     // 256 * 1000 * 4
   localparam longint BLUE_DIV_Q8    = 64'sd10240;       // 256 * 40
   localparam longint RED_DIV_Q8     = 64'sd5120;        // 256 * 20

   typedef struct packed {
      logic [RAW_W-1:0] depth_raw;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic [MAP_COL_W-1:0] map_col;
      logic [MAP_ROW_W-1:0] map_row;
      logic [BLUE_W-1:0]    blue_level;
      logic [RED_W-1:0]     red_level;
   } map_point_type;

   // One directed pixel; by_hand rows carry their expected point, the rest are predicted
   typedef struct packed {
      logic [RAW_W-1:0]     depth_raw;
      logic [COL_W-1:0]     column;
      logic [ROW_W-1:0]     row;
      logic                 by_hand;
      logic                 kept;
      logic [MAP_COL_W-1:0] map_col;
      logic [MAP_ROW_W-1:0] map_row;
      logic [BLUE_W-1:0]    blue_level;
      logic [RED_W-1:0]     red_level;
   } probe_row_type;

   // Directed pixels under the reset register values (depth in mm, 640 wide frame)
   localparam probe_row_type PROBE_ROWS [NUM_PROBES] = '{
      '{16'd1000,  12'd1,    12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd0,    12'd2,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd0,     12'd320,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd640,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd4092, 12'd4092, 1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd65535, 12'd4095, 12'd4095, 1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd320,  12'd4092, 1'b1, 1'b1, 10'd320, 9'd120, 7'd25, 8'd150},
      '{16'd199,   12'd320,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd200,   12'd320,  12'd0,    1'b1, 1'b1, 10'd320, 9'd24,  7'd5,  8'd190},
      '{16'd3999,  12'd320,  12'd8,    1'b1, 1'b1, 10'd320, 9'd479, 7'd99, 8'd0},
      '{16'd4000,  12'd320,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd4001,  12'd320,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd65535, 12'd320,  12'd0,    1'b1, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd0,    12'd0,    1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd3000,  12'd0,    12'd0,    1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1000,  12'd636,  12'd0,    1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd3000,  12'd636,  12'd4,    1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd2500,  12'd100,  12'd12,   1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0},
      '{16'd1234,  12'd500,  12'd400,  1'b0, 1'b0, 10'd0,   9'd0,   7'd0,  8'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [RAW_W-1:0]      req_depth_raw = '0;
   logic [COL_W-1:0]      req_column = '0;
   logic [ROW_W-1:0]      req_row = '0;
   logic                  rsp_valid;
   logic [MAP_COL_W-1:0]  rsp_map_col;
   logic [MAP_ROW_W-1:0]  rsp_map_row;
   logic [BLUE_W-1:0]     rsp_blue_level;
   logic [RED_W-1:0]      rsp_red_level;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEPTH_SCALE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register copies used for prediction
   logic [SCALE_W-1:0]    cfg_scale = DEPTH_SCALE_RST;
   logic [FW_W-1:0]       cfg_width = FRAME_WIDTH_RST;
   logic [RECIP_W-1:0]    cfg_recip = WIDTH_RECIP_RST;

   longint                tan_q14 [TAN_TABLE_DEPTH];
   map_point_type         pending_points [$];
   int                    mismatch_count = 0;
   int                    stall_cycles = 0;

   depth_to_topdown_map_projection DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_depth_raw  (req_depth_raw),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_map_col    (rsp_map_col),
      .rsp_map_row    (rsp_map_row),
      .rsp_blue_level (rsp_blue_level),
      .rsp_red_level  (rsp_red_level),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tangent of table entry in Q2.14: sine and cosine by five Taylor terms in Q30
   function automatic longint tangent_q14(int entry);
      longint steps;
      longint ang;
      longint ang_sq;
      longint sin_acc;
      longint cos_acc;
      longint sin_term;
      longint cos_term;
      longint ratio;
      steps    = longint'(entry) - longint'(TAN_TABLE_DEPTH / 2);
      ang      = ((steps < 0 ? -steps : steps) * ANGLE_SPAN_Q30) / TAN_TABLE_DEPTH;
      ang_sq   = (ang * ang) >>> 30;
      sin_acc  = ang;
      cos_acc  = UNIT_Q30;
      sin_term = ang;
      cos_term = UNIT_Q30;
      for (int k = 1; k <= 4; k++) begin
         sin_term = ((sin_term * ang_sq) >>> 30) / ((2 * k) * (2 * k + 1));
         cos_term = ((cos_term * ang_sq) >>> 30) / ((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sin_acc = sin_acc - sin_term;
            cos_acc = cos_acc - cos_term;
         end else begin
            sin_acc = sin_acc + sin_term;
            cos_acc = cos_acc + cos_term;
         end
      end
      ratio = ((sin_acc <<< 14) + cos_acc / 2) / cos_acc;
      return (steps < 0) ? -ratio : ratio;
   endfunction

   // Map point of one pixel under the current registers; returns 0 when no point is plotted
   function automatic bit project_pixel(input pixel_type px, output map_point_type pt);
      longint d8;
      longint angle;
      longint entry;
      longint tn;
      longint tmag;
      longint offset;
      longint mx;
      longint my;
      pt = '0;
      if (px.column[1:0] != 2'd0 || px.row[1:0] != 2'd0) return 1'b0;
      if (longint'(px.column) >= longint'(cfg_width)) return 1'b0;
      if (longint'(px.row) >= longint'(MAX_FRAME_HEIGHT)) return 1'b0;
      if (px.depth_raw == '0) return 1'b0;
      d8 = (longint'(px.depth_raw) * longint'(cfg_scale)) >>> 8;
      if (d8 < NEAR_MM_Q8 || d8 > FAR_MM_Q8) return 1'b0;
      // angle ratio, shifted to be non-negative over the field of view
      angle = (2 * longint'(px.column) - longint'(cfg_width)) * longint'(cfg_recip)
              + (64'sd1 <<< 24);
      if (angle < 0) begin
         entry = 0;
      end else begin
         entry = (angle * TAN_TABLE_DEPTH) >>> 25;
         if (entry > TAN_TABLE_DEPTH - 1) entry = TAN_TABLE_DEPTH - 1;
      end
      tn     = tan_q14[entry];
      tmag   = (tn < 0) ? -tn : tn;
      offset = (d8 * tmag * MAP_WIDTH) / OFFSET_DIV;
      if (tn < 0) offset = -offset;
      mx = MAP_WIDTH / 2 + offset;
      my = (d8 * MAP_HEIGHT) / ROW_DIV;
      if (mx < 0 || mx >= MAP_WIDTH || my < 0 || my >= MAP_HEIGHT) return 1'b0;
      pt.map_col    = MAP_COL_W'(mx);
      pt.map_row    = MAP_ROW_W'(my);
      pt.blue_level = BLUE_W'(d8 / BLUE_DIV_Q8);
      pt.red_level  = RED_W'((FAR_MM_Q8 - d8) / RED_DIV_Q8);
      return 1'b1;
   endfunction

   // Mostly well-formed pixels inside the frame and distance band, the rest raw noise
   function automatic pixel_type draw_pixel(output bit shaped);
      pixel_type px;
      longint span;
      longint lo;
      longint hi;
      int     pick;
      px.depth_raw = RAW_W'($urandom);
      px.column    = COL_W'($urandom);
      px.row       = ROW_W'($urandom);
      shaped = ($urandom_range(99) < 75) && (cfg_width != '0);
      if (shaped) begin
         span       = (cfg_width > 13'd4096) ? 4096 : longint'(cfg_width);
         px.column  = COL_W'(4 * $urandom_range(int'((span + 3) / 4) - 1));
         px.row     = ROW_W'(4 * $urandom_range(MAX_FRAME_HEIGHT / 4 - 1));
         if (cfg_scale != '0) begin
            lo = (64'sd13107200 + longint'(cfg_scale) - 1) / longint'(cfg_scale);
            hi = 64'sd262144255 / longint'(cfg_scale);
            if (lo < 1) lo = 1;
            if (hi > 65535) hi = 65535;
            if (lo <= hi) begin
               pick = $urandom_range(9);
               // distance band edges now and then
               case (pick)
                  0:       px.depth_raw = RAW_W'(lo);
                  1:       px.depth_raw = RAW_W'(hi);
                  2:       px.depth_raw = RAW_W'(lo - 1);
                  3:       px.depth_raw = RAW_W'((hi < 65535) ? hi + 1 : hi);
                  default: px.depth_raw = RAW_W'($urandom_range(int'(hi), int'(lo)));
               endcase
            end
         end
      end
      return px;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 4);
   endfunction

   // Present one pixel after an optional gap and wait for its transfer
   task automatic offer_pixel(input pixel_type px, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_depth_raw <= px.depth_raw;
      req_column    <= px.column;
      req_row       <= px.row;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic predict_transfer(input pixel_type px);
      map_point_type pt;
      if (project_pixel(px, pt)) pending_points.push_back(pt);
   endtask

   // Stop sending until every expected point has come out, then let the pipe empty
   task automatic hold_until_drained(input int extra);
      start <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] scale,
                                input logic [CSR_DATA_W-1:0] width_word,
                                input logic [CSR_DATA_W-1:0] recip);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEPTH_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width_word;
      @(posedge clock);
      csr_index <= CSR_WIDTH_RECIP;
      csr_wdata <= recip;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_scale = scale[SCALE_W-1:0];
      cfg_width = width_word[FW_W-1:0];
      cfg_recip = recip[RECIP_W-1:0];
   endtask

   task automatic note_mismatch(input string what, input map_point_type want,
                                input map_point_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: map_col %0d/%0d map_row %0d/%0d blue %0d/%0d red %0d/%0d",
                  $realtime, what, want.map_col, got.map_col, want.map_row, got.map_row,
                  want.blue_level, got.blue_level, want.red_level, got.red_level);
      end
   endtask

   // Point checker: each strobed point against the oldest expectation (expected/actual)
   always @(posedge clock) begin : check_points
      map_point_type got;
      map_point_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_map_col, rsp_map_row, rsp_blue_level, rsp_red_level};
         if (pending_points.size() == 0) begin
            note_mismatch("point with none expected", '0, got);
         end else begin
            want = pending_points.pop_front();
            if (got.map_col !== want.map_col || got.map_row !== want.map_row ||
                got.blue_level !== want.blue_level || got.red_level !== want.red_level) begin
               note_mismatch("point mismatch", want, got);
            end
         end
      end
   end

   // Watchdog: cycles with neither a pixel transfer nor a point
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("depth_to_topdown_map_projection regression: fail");
            $finish;
         end
      end
   end

   initial begin
      probe_row_type probe;
      pixel_type     px;
      map_point_type pt;
      bit            shaped;
      bit            steady;
      int            shaped_pixels;
      int            phase;
      int            span;
      int            width_pick;

      for (int i = 0; i < TAN_TABLE_DEPTH; i++) tan_q14[i] = tangent_q14(i);
      shaped_pixels = 0;
      phase = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels under reset register values
      for (int i = 0; i < NUM_PROBES; i++) begin
         probe = PROBE_ROWS[i];
         px = '{probe.depth_raw, probe.column, probe.row};
         offer_pixel(px, pick_gap());
         if (probe.by_hand) begin
            pt = '{probe.map_col, probe.map_row, probe.blue_level, probe.red_level};
            if (probe.kept) pending_points.push_back(pt);
         end else begin
            predict_transfer(px);
         end
      end
      hold_until_drained(DRAIN_CYCLES);

      // Random phases, each under its own register setting
      while (shaped_pixels < SHAPED_GOAL) begin
         case (phase)
            0: load_settings(24'hFFFFFF, 24'd4096, 24'd4096);
            1: load_settings(24'd0, {11'($urandom), 13'h1FFF}, 24'hFFFFFF);
            2: load_settings(24'd65536, 24'd0, 24'd0);
            3: load_settings(24'd1, 24'd4096, 24'hFFFFFF);
            4: load_settings(24'd65536, 24'd640, 24'hFFFFFF);
            5: load_settings(24'd32768, 24'd8191, 24'd0);
            6: load_settings(24'd65536, 24'd1, 24'hFFFFFF);
            default: begin
               if ($urandom_range(5) == 0) begin
                  load_settings(24'($urandom), 24'($urandom), 24'($urandom));
               end else begin
                  width_pick = $urandom_range(4096, 1);
                  load_settings(24'($urandom_range(524288, 8192)), 24'(width_pick),
                                24'((1 << 24) / width_pick + $urandom_range(8) - 4));
               end
            end
         endcase
         steady = ($urandom_range(3) == 0);
         span = $urandom_range(60, 20);
         repeat (span) begin
            px = draw_pixel(shaped);
            offer_pixel(px, steady ? 0 : pick_gap());
            predict_transfer(px);
            if (shaped) shaped_pixels++;
            if ($urandom_range(49) == 0) hold_until_drained(0);
         end
         hold_until_drained(DRAIN_CYCLES);
         phase++;
      end

      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("depth_to_topdown_map_projection regression: pass");
      end else begin
         $display("depth_to_topdown_map_projection regression: fail");
      end
      $finish;
   end

endmodule
